@@ rtl/ccks_pkg.sv @@
// ChaCha20 keystream package: constants, types and the quarter-round and round functions.
package ccks_pkg;
    localparam int ROUND_COUNT_DEF = 20;
    localparam int WORDS = 16;
    localparam int CFG_COUNT = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY45 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY67 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE01 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE2 = 3'd5;
    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    typedef logic [31:0] t_word;
    typedef t_word [WORDS-1:0] t_state;

    function automatic t_word rotl(input t_word v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    function automatic t_state quarter(input t_state s, input int a, input int b,
                                       input int c, input int d);
        t_state t;
        t = s;
        t[a] = t[a] + t[b]; t[d] = rotl(t[d] ^ t[a], 16);
        t[c] = t[c] + t[d]; t[b] = rotl(t[b] ^ t[c], 12);
        t[a] = t[a] + t[b]; t[d] = rotl(t[d] ^ t[a], 8);
        t[c] = t[c] + t[d]; t[b] = rotl(t[b] ^ t[c], 7);
        quarter = t;
    endfunction

    function automatic t_state round_fn(input t_state s, input logic diag);
        t_state t;
        t = s;
        if (!diag) begin
            t = quarter(t, 0, 4, 8, 12);
            t = quarter(t, 1, 5, 9, 13);
            t = quarter(t, 2, 6, 10, 14);
            t = quarter(t, 3, 7, 11, 15);
        end else begin
            t = quarter(t, 0, 5, 10, 15);
            t = quarter(t, 1, 6, 11, 12);
            t = quarter(t, 2, 7, 8, 13);
            t = quarter(t, 3, 4, 9, 14);
        end
        round_fn = t;
    endfunction
endpackage

@@ rtl/chacha20_block_keystream_top.sv @@
// ChaCha20 block keystream generator: one round per pipeline stage, word serializer.
//  channel | dir | contents
//  s_axis  | in  | tdata[31:0] block_counter
//  m_axis  | out | tdata[31:0] keystream_word, tuser[3:0] word_index, tlast last_word
//  cfg     | in  | i_cfg_we, i_cfg_idx, i_cfg_data (64 bits)
// The counter enters the init stage, runs one round per stage, then loads the serializer.
// A block is then sent as 16 words, one per cycle while m_axis_tready is high; the
// sustained counter rate is set by the single output word port.
// Pipeline advances whenever its head is empty or moves into the serializer.
// Reset (synchronous, active low) clears valid bits and config registers.
module chacha20_block_keystream_top #(
    parameter int ROUND_COUNT = ccks_pkg::ROUND_COUNT_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [31:0]                          s_axis_tdata, // block_counter
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [31:0]                          m_axis_tdata, // keystream_word
    output logic [3:0]                           m_axis_tuser, // word_index
    output logic                                 m_axis_tlast,
    input  logic                                 i_cfg_we,
    input  logic [ccks_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ccks_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import ccks_pkg::*;

    logic [CFG_DATA_W-1:0] r_cfg [CFG_COUNT];
    t_state r_work [ROUND_COUNT+1];
    t_word  r_ctr  [ROUND_COUNT+1];
    logic [ROUND_COUNT:0] r_vld;
    t_state r_out;
    logic   r_ovld;
    logic [3:0] r_widx;
    logic   adv, out_load, out_done;
    t_state init_st, fin_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_COUNT; i++) r_cfg[i] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY01, CFG_KEY23, CFG_KEY45, CFG_KEY67, CFG_NONCE01:
                    r_cfg[i_cfg_idx] <= i_cfg_data;
                CFG_NONCE2: r_cfg[i_cfg_idx] <= {32'd0, i_cfg_data[31:0]};
                default: ;
            endcase
        end
    end

    function automatic t_state mk_init(input t_word ctr);
        t_state s;
        s[0] = SIGMA0; s[1] = SIGMA1; s[2] = SIGMA2; s[3] = SIGMA3;
        for (int i = 0; i < 4; i++) begin
            s[4+2*i] = r_cfg[i][31:0];
            s[5+2*i] = r_cfg[i][63:32];
        end
        s[12] = ctr;
        s[13] = r_cfg[CFG_NONCE01][31:0];
        s[14] = r_cfg[CFG_NONCE01][63:32];
        s[15] = r_cfg[CFG_NONCE2][31:0];
        mk_init = s;
    endfunction

    assign out_done = r_ovld && m_axis_tready && (r_widx == 4'd15);
    assign out_load = r_vld[ROUND_COUNT] && (!r_ovld || out_done);
    assign adv = !r_vld[ROUND_COUNT] || out_load;
    assign s_axis_tready = adv;

    always_comb begin
        init_st = mk_init(r_ctr[ROUND_COUNT]);
    end

    always_comb begin
        for (int i = 0; i < WORDS; i++) fin_st[i] = r_work[ROUND_COUNT][i] + init_st[i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[ROUND_COUNT-1:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_work[0] <= mk_init(s_axis_tdata);
            r_ctr[0]  <= s_axis_tdata;
            for (int k = 1; k <= ROUND_COUNT; k++) begin
                r_work[k] <= round_fn(r_work[k-1], 1'((k - 1) % 2));
                r_ctr[k]  <= r_ctr[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
            r_widx <= '0;
        end else begin
            if (out_load) begin
                r_ovld <= 1'b1;
                r_widx <= '0;
                r_out  <= fin_st;
            end else if (out_done) begin
                r_ovld <= 1'b0;
            end else if (r_ovld && m_axis_tready) begin
                r_widx <= r_widx + 4'd1;
            end
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_out[r_widx];
    assign m_axis_tuser  = r_widx;
    assign m_axis_tlast  = (r_widx == 4'd15);

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_done && !out_load |=> !r_ovld)
        else $error("serializer did not stop after last word");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && !m_axis_tready |=> $stable(r_widx) && r_ovld)
        else $error("word index moved while stalled");
    a_head_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ROUND_COUNT] && !adv |=> r_vld[ROUND_COUNT])
        else $error("pipeline head lost");
endmodule
